// ----- rtl/lfu_cache_table_macros.svh -----
// assertion macros for the lfu cache table
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define LFU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LFU_ASSERT_NOW(label, cond)
`define LFU_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/lfu_pkg.sv -----
// shared types and constants for the lfu cache table
`default_nettype none
package lfu_pkg;
  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_COUNT_BITS = 16;
  localparam int unsigned CAP_W          = 5;
  localparam int unsigned WORD_W         = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic upd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic need_upd;
  } status_t;
endpackage
`default_nettype wire

// ----- rtl/lfu_cache_table.sv -----
// lfu cache table: two passes over the entry memory per word
// a get miss or an ignored set skips the update pass and makes only the scan pass
// the entry memory is read once for the key/victim scan and once for the rank write-back
// a new word is taken only in idle, after the last result has gone to the result register
// reset: store empty, capacity 16; a capacity write also empties the store
// result register lets the next word enter while the last result waits
`default_nettype none
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int unsigned COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // lookup_key[31:0], write_value[63:32]
  input  wire  [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // hit[0], read_value[32:1], evicted[33],
                                 // evicted_key[65:34], zero[71:66]
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          st;
  logic             hit, ev;
  logic [WORD_W-1:0] rd, evk;

  // apb: capacity register at byte address zero, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cfg_clear_i (cfg_wr),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .st_o   (st),
    .cap_i  (cap_q),
    .act_i  (s_tuser[0]),
    .key_i  (s_tdata[31:0]),
    .val_i  (s_tdata[63:32]),
    .hit_o  (hit),
    .rd_o   (rd),
    .ev_o   (ev),
    .evk_o  (evk)
  );

  assign m_tdata = {6'b0, evk, ev, rd, hit};
endmodule
`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
// sequencer for the lfu cache table: scan pass, update pass, result hand-off
`default_nettype none
`include "lfu_cache_table_macros.svh"
module lfu_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire             m_tready,
  input  wire             cfg_clear_i,
  input  lfu_pkg::status_t st_i,
  output lfu_pkg::cmd_t    cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SCAN, SCAN_TAIL, DECIDE, UPD, UPD_TAIL, FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fin_ok;

  assign s_tready = (state_q == IDLE);
  assign m_tvalid = out_valid_q;
  assign fin_ok   = !out_valid_q || m_tready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.clear = cfg_clear_i;
    if (out_valid_q && m_tready) out_valid_d = 1'b0;
    unique case (state_q)
      IDLE: begin
        if (s_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = SCAN;
        end
      end
      SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.last) state_d = SCAN_TAIL;
      end
      SCAN_TAIL: state_d = DECIDE;
      DECIDE: state_d = st_i.need_upd ? UPD : FIN;
      UPD: begin
        cmd_o.upd = 1'b1;
        if (st_i.last) state_d = UPD_TAIL;
      end
      UPD_TAIL: state_d = FIN;
      FIN: begin
        if (fin_ok) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LFU_ASSERT_NOW(a_fin_no_overwrite, !cmd_o.finish || !out_valid_q || m_tready)
  `LFU_ASSERT_NOW(a_one_phase, $onehot0({cmd_o.load, cmd_o.scan, cmd_o.upd, cmd_o.finish}))
  `LFU_ASSERT_NEXT(a_load_starts_scan, cmd_o.load, cmd_o.scan && !s_tready)
endmodule
`default_nettype wire

// ----- rtl/lfu_dpath.sv -----
// entry memory, scan bookkeeping, valid bits and result register
`default_nettype none
module lfu_dpath #(
  parameter int unsigned ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int unsigned COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lfu_pkg::cmd_t                 cmd_i,
  output lfu_pkg::status_t              st_o,
  input  wire [lfu_pkg::CAP_W-1:0]      cap_i,
  input  wire                           act_i,
  input  wire [lfu_pkg::WORD_W-1:0]     key_i,
  input  wire [lfu_pkg::WORD_W-1:0]     val_i,
  output logic                          hit_o,
  output logic [lfu_pkg::WORD_W-1:0]    rd_o,
  output logic                          ev_o,
  output logic [lfu_pkg::WORD_W-1:0]    evk_o
);
  import lfu_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;
  localparam int unsigned K_LO = 0;
  localparam int unsigned V_LO = WORD_W;
  localparam int unsigned C_LO = 2 * WORD_W;
  localparam int unsigned R_LO = 2 * WORD_W + COUNT_BITS;
  localparam int unsigned EW   = R_LO + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [EW-1:0] mem_q [ENTRIES];
  logic [EW-1:0] rdata_q;
  logic [IW-1:0] addr_q, ridx_q;
  logic          rv_scan_q, rv_upd_q;
  logic [ENTRIES-1:0] valid_q;
  logic [OW-1:0] occ_q;

  logic              act_q;
  logic [WORD_W-1:0] key_q, val_q;

  logic          found_q, vfound_q, ffound_q;
  logic [IW-1:0] m_q, v_q, f_q, mrank_q, vrank_q;
  logic [WORD_W-1:0] mval_q, vkey_q;
  logic [COUNT_BITS-1:0] vcnt_q;

  logic [WORD_W-1:0]     e_key, e_val;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [IW-1:0]         e_rank;
  logic                  e_vld;

  assign e_key  = rdata_q[K_LO +: WORD_W];
  assign e_val  = rdata_q[V_LO +: WORD_W];
  assign e_cnt  = rdata_q[C_LO +: COUNT_BITS];
  assign e_rank = rdata_q[R_LO +: IW];
  assign e_vld  = valid_q[ridx_q];

  // decision made from the finished scan
  logic [CW-1:0] cap_eff;
  logic do_set, evict, ins, use_rr;
  logic [IW-1:0] slot, rr;

  always_comb begin
    cap_eff = (CW'(cap_i) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_i);
    do_set  = (act_q == ACT_SET) && (cap_eff != '0);
    ins     = do_set && !found_q;
    evict   = ins && vfound_q && (CW'(occ_q) >= cap_eff);
    slot    = (evict && !(ffound_q && f_q < v_q)) ? v_q : f_q;
    use_rr  = found_q || evict;
    rr      = found_q ? mrank_q : vrank_q;
  end

  assign st_o.last     = (addr_q == LAST_IDX);
  assign st_o.need_upd = found_q || ins;

  // update of one entry in the second pass
  logic          we;
  logic [EW-1:0] wd;

  always_comb begin
    we = 1'b0;
    wd = rdata_q;
    if (rv_upd_q) begin
      if (ins && ridx_q == slot) begin
        we = 1'b1;
        wd = {IW'(0), COUNT_BITS'(1), val_q, key_q};
      end else if (e_vld && !(evict && ridx_q == v_q)) begin
        we = 1'b1;
        if (found_q && ridx_q == m_q) begin
          wd[R_LO +: IW] = '0;
          wd[C_LO +: COUNT_BITS] = (e_cnt == '1) ? e_cnt : e_cnt + COUNT_BITS'(1);
          if (act_q == ACT_SET) wd[V_LO +: WORD_W] = val_q;
        end else if (!use_rr || e_rank < rr) begin
          wd[R_LO +: IW] = e_rank + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan || cmd_i.upd) rdata_q <= mem_q[addr_q];
    if (we) mem_q[ridx_q] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rv_scan_q <= 1'b0;
      rv_upd_q  <= 1'b0;
      valid_q   <= '0;
      occ_q     <= '0;
      found_q   <= 1'b0;
      vfound_q  <= 1'b0;
      ffound_q  <= 1'b0;
    end else begin
      rv_scan_q <= cmd_i.scan;
      rv_upd_q  <= cmd_i.upd;
      if (cmd_i.scan || cmd_i.upd) begin
        addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + IW'(1);
      end
      if (cmd_i.load) begin
        addr_q   <= '0;
        found_q  <= 1'b0;
        vfound_q <= 1'b0;
        ffound_q <= 1'b0;
      end
      if (rv_scan_q) begin
        if (e_vld && e_key == key_q && !found_q) found_q <= 1'b1;
        if (e_vld && (!vfound_q || e_cnt < vcnt_q ||
                      (e_cnt == vcnt_q && e_rank > vrank_q))) vfound_q <= 1'b1;
        if (!e_vld && !ffound_q) ffound_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (evict) valid_q[v_q] <= 1'b0;
        if (ins) valid_q[slot] <= 1'b1;
        if (ins && !evict) occ_q <= occ_q + OW'(1);
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        occ_q   <= '0;
      end
    end
  end

  // payload, scan-result and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= act_i;
      key_q <= key_i;
      val_q <= val_i;
    end
    if (rv_scan_q) begin
      if (e_vld && e_key == key_q && !found_q) begin
        m_q     <= ridx_q;
        mrank_q <= e_rank;
        mval_q  <= e_val;
      end
      if (e_vld && (!vfound_q || e_cnt < vcnt_q ||
                    (e_cnt == vcnt_q && e_rank > vrank_q))) begin
        v_q     <= ridx_q;
        vcnt_q  <= e_cnt;
        vrank_q <= e_rank;
        vkey_q  <= e_key;
      end
      if (!e_vld && !ffound_q) f_q <= ridx_q;
    end
    ridx_q <= addr_q;
    if (cmd_i.finish) begin
      hit_o <= found_q;
      rd_o  <= (act_q == ACT_SET) ? '0 : (found_q ? mval_q : '1);
      ev_o  <= evict;
      evk_o <= evict ? vkey_q : '0;
    end
  end
endmodule
`default_nettype wire
